### sv/segment_box_intersection_assert.svh
// ---------------------------------------------------------------------------
// Segment/box intersection assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_BOX_INTERSECTION_ASSERT_SVH
`define SEGMENT_BOX_INTERSECTION_ASSERT_SVH

`ifndef SYNTHESIS
`define SBI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBI_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SBI_ASSERT(label, prop, msg)
`define SBI_ASSERT_NEVER(label, expr, msg)
`endif

`endif

### sv/sbi_pkg.sv
// ---------------------------------------------------------------------------
// Segment/box intersection package
// Widths, register indexes and item types shared by all modules.
// ---------------------------------------------------------------------------
package sbi_pkg;

    localparam int CW         = 32;       // coordinate width
    localparam int T_BITS     = 24;       // fraction bits of t
    localparam int QW         = T_BITS + 1;
    localparam int MW         = CW + 1;   // magnitude of a coordinate difference
    localparam int DIV_STAGES = QW;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int IDXW       = 3;

    typedef logic [CW-1:0] coord_t;
    typedef logic [MW-1:0] mag_t;
    typedef logic [QW-1:0] tval_t;
    typedef logic signed [CW+1:0] wide_t;

    typedef enum logic [IDXW-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_idx_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } box_t;

    typedef struct packed {
        logic         in_box;
        logic         over;
        logic [2:0]   cand;
        logic [2:0]   dneg;
        coord_t [2:0] s;
        coord_t [2:0] plane;
        mag_t [2:0]   dmag;
        mag_t [2:0]   nmag;
    } fe_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic wide_t sext(coord_t v);
        return {{2{v[CW-1]}}, v};
    endfunction

endpackage

### sv/sbi_seg_if.sv
// ---------------------------------------------------------------------------
// Segment input channel
// Valid/ready channel carrying one segment as start and end points.
// ---------------------------------------------------------------------------
interface sbi_seg_if import sbi_pkg::*;;
    logic              valid;
    logic              ready;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

### sv/sbi_res_if.sv
// ---------------------------------------------------------------------------
// Intersection result channel
// Valid/ready channel carrying one intersection result.
// ---------------------------------------------------------------------------
interface sbi_res_if import sbi_pkg::*;;
    logic              valid;
    logic              ready;
    logic              hit;
    logic              started_inside;
    logic [1:0]        hit_axis;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;

    modport source (output valid, hit, started_inside, hit_axis, point_x, point_y,
                    point_z, input ready);
    modport sink (input valid, hit, started_inside, hit_axis, point_x, point_y,
                  point_z, output ready);
endinterface

### sv/sbi_front.sv
// ---------------------------------------------------------------------------
// Segment classifier
// Finds candidate planes, numerator and direction magnitudes per axis.
// ---------------------------------------------------------------------------
module sbi_front import sbi_pkg::*;
(
    sbi_seg_if.sink  seg,
    input  box_t     box,
    input  q_stat_t  qstat,
    output logic     push,
    output fe_item_t item
);

    coord_t [2:0] s;
    coord_t [2:0] e;

    assign s = {coord_t'(seg.start_z), coord_t'(seg.start_y), coord_t'(seg.start_x)};
    assign e = {coord_t'(seg.end_z), coord_t'(seg.end_y), coord_t'(seg.end_x)};

    assign seg.ready = !qstat.full;
    assign push      = seg.valid && !qstat.full;

    always_comb
    begin
        logic [2:0]        oc;
        logic [2:0]        ov;
        logic              below;
        logic              above;
        logic              live;
        logic signed [MW-1:0] d;
        logic signed [MW-1:0] num;
        coord_t            pl;

        oc   = '0;
        ov   = '0;
        item = '0;
        for (int i = 0; i < 3; i++)
        begin
            below = $signed(s[i]) < $signed(box.lo[i]);
            above = $signed(s[i]) > $signed(box.hi[i]);
            pl    = below ? box.lo[i] : box.hi[i];
            d     = $signed({e[i][CW-1], e[i]}) - $signed({s[i][CW-1], s[i]});
            num   = $signed({pl[CW-1], pl}) - $signed({s[i][CW-1], s[i]});
            oc[i] = below || above;
            item.s[i]     = s[i];
            item.plane[i] = pl;
            item.dneg[i]  = d[MW-1];
            item.dmag[i]  = d[MW-1] ? mag_t'(-d) : mag_t'(d);
            item.nmag[i]  = num[MW-1] ? mag_t'(-num) : mag_t'(num);
            // candidate only if t would be non-negative
            live  = oc[i] && (d != '0) && (num[MW-1] == d[MW-1]);
            ov[i] = live && (item.nmag[i] > item.dmag[i]);
            item.cand[i] = live && !ov[i];
        end
        item.in_box = !(|oc);
        item.over   = |ov;
    end

endmodule

### sv/sbi_queue.sv
// ---------------------------------------------------------------------------
// Classified item queue
// Small FIFO between the classifier and the intersection pipeline.
// ---------------------------------------------------------------------------
module sbi_queue import sbi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fe_item_t wdata,
    input  logic     pop,
    output fe_item_t head,
    output q_stat_t  qstat
);

    fe_item_t        mem [QDEPTH];
    logic [QAW-1:0]  wptr_reg;
    logic [QAW-1:0]  rptr_reg;
    logic [QAW:0]    count_reg;
    logic [QAW:0]    count_next;

    assign head        = mem[rptr_reg];
    assign qstat.full  = count_reg == (QAW+1)'(QDEPTH);
    assign qstat.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### sv/sbi_div.sv
// ---------------------------------------------------------------------------
// Pipelined fraction divider
// floor(n * 2^T_BITS / d) for n <= d, one quotient bit per stage.
// ---------------------------------------------------------------------------
module sbi_div import sbi_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  mag_t  n,
    input  mag_t  d,
    output tval_t q
);

    mag_t  r_reg [DIV_STAGES];
    mag_t  d_reg [DIV_STAGES];
    tval_t q_reg [DIV_STAGES];

    // integer bit: n <= d, so at most one subtraction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= (n >= d) ? n - d : n;
            d_reg[0] <= d;
            q_reg[0] <= tval_t'(n >= d);
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++)
    begin : g_stage
        logic [MW:0] r2;
        logic        ge;

        assign r2 = {r_reg[k-1], 1'b0};
        assign ge = r2 >= {1'b0, d_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= ge ? MW'(r2 - {1'b0, d_reg[k-1]}) : MW'(r2);
                d_reg[k] <= d_reg[k-1];
                q_reg[k] <= {q_reg[k-1][QW-2:0], ge};
            end
        end
    end

    assign q = q_reg[DIV_STAGES-1];

endmodule

### sv/sbi_back.sv
// ---------------------------------------------------------------------------
// Intersection pipeline
// Divides, picks the entry plane, interpolates and bounds-checks the point.
// ---------------------------------------------------------------------------
module sbi_back import sbi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  box_t     box,
    input  fe_item_t head,
    input  q_stat_t  qstat,
    output logic     pop,
    sbi_res_if.source res
);

    logic       en;
    tval_t [2:0] t;

    logic       v_reg [DIV_STAGES];
    fe_item_t   it_reg [DIV_STAGES];

    logic       b_v_reg;
    fe_item_t   b_it_reg;
    tval_t      b_t_reg;
    logic [1:0] b_axis_reg;
    logic       b_found_reg;

    logic       m_v_reg;
    fe_item_t   m_it_reg;
    logic [1:0] m_axis_reg;
    logic       m_found_reg;
    mag_t [2:0] m_p_reg;

    logic       o_v_reg;
    logic       o_hit_reg;
    logic       o_si_reg;
    logic [1:0] o_axis_reg;
    coord_t [2:0] o_pt_reg;

    // whole pipeline advances together; the output register is the only hold point
    assign en  = !o_v_reg || res.ready;
    assign pop = en && !qstat.empty;

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        sbi_div u_div (
            .clk (clk),
            .en  (en),
            .n   (head.nmag[g]),
            .d   (head.dmag[g]),
            .q   (t[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                v_reg[k] <= 1'b0;
            b_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= !qstat.empty;
            for (int k = 1; k < DIV_STAGES; k++)
                v_reg[k] <= v_reg[k-1];
            b_v_reg <= v_reg[DIV_STAGES-1];
            m_v_reg <= b_v_reg;
            o_v_reg <= m_v_reg;
        end
    end

    // largest t wins, lowest axis on ties
    logic [1:0] best;
    logic       found;
    tval_t      tbest;

    always_comb
    begin
        best  = AXIS_X;
        found = 1'b0;
        tbest = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (it_reg[DIV_STAGES-1].cand[i] && (!found || tbest < t[i]))
            begin
                best  = 2'(i);
                found = 1'b1;
                tbest = t[i];
            end
        end
    end

    logic [QW+MW-1:0] prod [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prod[i] = (QW+MW)'(b_t_reg) * (QW+MW)'(b_it_reg.dmag[i]);
    end

    logic       f_hit;
    logic       f_si;
    logic [1:0] f_axis;
    coord_t [2:0] f_pt;

    always_comb
    begin
        wide_t  pw;
        logic   ok;

        ok     = m_found_reg && !m_it_reg.over;
        f_pt   = '0;
        for (int i = 0; i < 3; i++)
        begin
            // entry axis sits on its plane and is not bounds-checked
            if (m_axis_reg == 2'(i))
                pw = sext(m_it_reg.plane[i]);
            else
            begin
                if (m_it_reg.dneg[i])
                    pw = sext(m_it_reg.s[i]) - $signed({1'b0, m_p_reg[i]});
                else
                    pw = sext(m_it_reg.s[i]) + $signed({1'b0, m_p_reg[i]});
                if (pw < sext(box.lo[i]) || pw > sext(box.hi[i]))
                    ok = 1'b0;
            end
            f_pt[i] = pw[CW-1:0];
        end
        priority if (m_it_reg.in_box)
        begin
            f_hit  = 1'b1;
            f_si   = 1'b1;
            f_axis = AXIS_X;
            f_pt   = m_it_reg.s;
        end
        else if (ok)
        begin
            f_hit  = 1'b1;
            f_si   = 1'b0;
            f_axis = m_axis_reg;
        end
        else
        begin
            f_hit  = 1'b0;
            f_si   = 1'b0;
            f_axis = AXIS_X;
            f_pt   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg[0] <= head;
            for (int k = 1; k < DIV_STAGES; k++)
                it_reg[k] <= it_reg[k-1];

            b_it_reg    <= it_reg[DIV_STAGES-1];
            b_t_reg     <= tbest;
            b_axis_reg  <= best;
            b_found_reg <= found;

            m_it_reg    <= b_it_reg;
            m_axis_reg  <= b_axis_reg;
            m_found_reg <= b_found_reg;
            for (int i = 0; i < 3; i++)
                m_p_reg[i] <= prod[i][T_BITS +: MW];

            o_hit_reg  <= f_hit;
            o_si_reg   <= f_si;
            o_axis_reg <= f_axis;
            o_pt_reg   <= f_pt;
        end
    end

    assign res.valid          = o_v_reg;
    assign res.hit            = o_hit_reg;
    assign res.started_inside = o_si_reg;
    assign res.hit_axis       = o_axis_reg;
    assign res.point_x        = o_pt_reg[0];
    assign res.point_y        = o_pt_reg[1];
    assign res.point_z        = o_pt_reg[2];

endmodule

### sv/segment_box_intersection.sv
// ---------------------------------------------------------------------------
// Segment/box intersection
// First point where a segment meets an axis-aligned box (candidate planes).
// ---------------------------------------------------------------------------
//  channel   dir   handshake     payload
//  seg       in    valid/ready   start_x/y/z, end_x/y/z
//  res       out   valid/ready   hit, started_inside, hit_axis, point_x/y/z
//  config    in    write_en      reg_index, write_data
//
// One item per cycle sustained while res is ready; the path runs from queue
// read into divider stage 0 through 24 more divider stages, plane select and
// multiply to the check into the output register.
// The divider pipeline sets the latency: one quotient bit of t per stage.
// The back pipeline holds as a whole while res is stalled; the 4-entry queue
// keeps seg.ready high until it fills.
// Reset clears the box to zero and empties queue and pipeline.
// ---------------------------------------------------------------------------
`include "segment_box_intersection_assert.svh"

module segment_box_intersection import sbi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sbi_seg_if.sink         seg,
    sbi_res_if.source       res,
    input  logic            write_en,
    input  logic [IDXW-1:0] reg_index,
    input  logic [CW-1:0]   write_data
);

    box_t     box_reg;
    fe_item_t fe_item;
    fe_item_t head;
    q_stat_t  qstat;
    logic     push;
    logic     pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= '0;
        else if (write_en)
        begin
            unique case (reg_idx_t'(reg_index))
                REG_MIN_X: box_reg.lo[0] <= write_data;
                REG_MIN_Y: box_reg.lo[1] <= write_data;
                REG_MIN_Z: box_reg.lo[2] <= write_data;
                REG_MAX_X: box_reg.hi[0] <= write_data;
                REG_MAX_Y: box_reg.hi[1] <= write_data;
                REG_MAX_Z: box_reg.hi[2] <= write_data;
                default: ;
            endcase
        end
    end

    sbi_front u_front (
        .seg   (seg),
        .box   (box_reg),
        .qstat (qstat),
        .push  (push),
        .item  (fe_item)
    );

    sbi_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (fe_item),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    sbi_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .box   (box_reg),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .res   (res)
    );

    `SBI_ASSERT_NEVER(a_q_full_empty, qstat.full && qstat.empty, "queue full and empty")
    `SBI_ASSERT(a_miss_zero, res.valid && !res.hit |-> res.point_x == 0 && res.point_y == 0 && res.point_z == 0, "miss with nonzero point")
    `SBI_ASSERT(a_inside_hit, res.valid && res.started_inside |-> res.hit && res.hit_axis == AXIS_X, "inside start without hit")
    `SBI_ASSERT_NEVER(a_pop_empty, pop && qstat.empty, "pop from empty queue")

endmodule
